FILE: sv/nkrl_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and the name normalizing function for the record list.
// Depends on nothing; the datapath, controller, top and testbench refer to it by scoped names.
package nkrl_pkg;

	localparam int NAME_BYTES = 19;
	localparam logic [7:0] CHAR_NUL     = 8'h00;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
	localparam logic [7:0] CASE_OFFSET  = 8'h20;

	// Request codes.
	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_LOOKUP = 2'd2,
		CMD_LIST   = 2'd3
	} cmd_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	// A name packed as on the ports, first character in the top byte.
	typedef struct packed {
		logic [63:0] chars_0_7;
		logic [63:0] chars_8_15;
		logic [23:0] chars_16_18;
	} name_t;

	typedef struct packed {
		name_t              name;
		logic signed [31:0] id;
	} record_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    load;
		logic    rd_next;
		logic    wr_ins;
		logic    wr_move;
		logic    idx_clr;
		logic    idx_inc;
		logic    cnt_inc;
		logic    cnt_dec;
		logic    emit;
		status_t emit_status;
		logic    emit_rec;
		logic    emit_last;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		cmd_t cmd;
		logic full;
		logic empty;
		logic match;
		logic at_last;
		logic move_more;
	} dp_stat_t;

	// Zero every byte from the first NUL on and upper-case a..z before it.
	function automatic name_t normalize(name_t raw);
		logic [NAME_BYTES*8-1:0] w;
		logic                    ended;
		logic [7:0]              b;
		w = raw;
		ended = 1'b0;
		for (int i = 0; i < NAME_BYTES; i++) begin
			b = w[(NAME_BYTES-1-i)*8 +: 8];
			if (b == CHAR_NUL) begin
				ended = 1'b1;
			end
			if (ended) begin
				b = CHAR_NUL;
			end else if (b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z) begin
				b = b - CASE_OFFSET;
			end
			w[(NAME_BYTES-1-i)*8 +: 8] = b;
		end
		return name_t'(w);
	endfunction

endpackage

FILE: sv/nkrl_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; contents are undefined until written.
module nkrl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                            wr_data,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                            rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write when enabled, read every cycle into the output register.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

FILE: sv/nkrl_dp.sv
`timescale 1ns / 1ps
// Datapath of the record list: request registers, record RAM, counters, result registers.
// Depends on nkrl_pkg and nkrl_ram; driven by commands from nkrl_ctrl.
module nkrl_dp #(
	parameter int CAPACITY = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  nkrl_pkg::dp_cmd_t   cmd,
	output nkrl_pkg::dp_stat_t  stat,
	input  logic [1:0]          command,
	input  logic [63:0]         name_chars_0_7,
	input  logic [63:0]         name_chars_8_15,
	input  logic [23:0]         name_chars_16_18,
	input  logic signed [31:0]  record_id,
	output logic                done,
	output logic [1:0]          status,
	output logic [63:0]         out_chars_0_7,
	output logic [63:0]         out_chars_8_15,
	output logic [23:0]         out_chars_16_18,
	output logic signed [31:0]  out_id,
	output logic                last_of_run
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int REC_W = $bits(nkrl_pkg::record_t);

	nkrl_pkg::name_t    key_q;
	logic signed [31:0] id_q;
	nkrl_pkg::cmd_t     cmd_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [IDX_W-1:0]   idx_q;
	logic [CNT_W-1:0]   idx_p1;
	logic [CNT_W:0]     idx_p2;
	nkrl_pkg::name_t    raw_name;
	nkrl_pkg::record_t  rd_rec;
	logic [REC_W-1:0]   rd_data;
	logic [REC_W-1:0]   wr_data;
	logic [IDX_W-1:0]   wr_addr;
	logic [IDX_W-1:0]   rd_addr;

	assign raw_name = '{chars_0_7: name_chars_0_7, chars_8_15: name_chars_8_15,
		chars_16_18: name_chars_16_18};

	// Request registers; the key is normalized on the way in.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q <= nkrl_pkg::normalize(raw_name);
			id_q  <= record_id;
			cmd_q <= nkrl_pkg::cmd_t'(command);
		end
	end

	// Record count and walk position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else begin
			if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (cmd.cnt_dec) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	assign idx_p1 = CNT_W'(idx_q) + CNT_W'(1);
	assign idx_p2 = {1'b0, idx_p1} + (CNT_W + 1)'(1);

	// Inserts append at the count; close-up copies the next entry down one place.
	assign wr_addr = cmd.wr_ins ? cnt_q[IDX_W-1:0] : idx_q;
	assign wr_data = cmd.wr_ins ? REC_W'({key_q, id_q}) : rd_data;
	assign rd_addr = cmd.rd_next ? idx_p1[IDX_W-1:0] : idx_q;
	assign rd_rec  = nkrl_pkg::record_t'(rd_data);

	nkrl_ram #(
		.WIDTH(REC_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk    (clk),
		.wr_en  (cmd.wr_ins | cmd.wr_move),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Status back to the controller.
	always_comb begin
		stat.cmd       = cmd_q;
		stat.full      = (cnt_q == CNT_W'(CAPACITY));
		stat.empty     = (cnt_q == '0);
		stat.match     = (rd_rec.name == key_q);
		stat.at_last   = (idx_p1 == cnt_q);
		stat.move_more = (idx_p2 < {1'b0, cnt_q});
	end

	// Result registers; record fields are zero unless a record is shown.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			status      <= cmd.emit_status;
			last_of_run <= cmd.emit_last;
			if (cmd.emit_rec) begin
				out_chars_0_7   <= rd_rec.name.chars_0_7;
				out_chars_8_15  <= rd_rec.name.chars_8_15;
				out_chars_16_18 <= rd_rec.name.chars_16_18;
				out_id          <= rd_rec.id;
			end else begin
				out_chars_0_7   <= '0;
				out_chars_8_15  <= '0;
				out_chars_16_18 <= '0;
				out_id          <= '0;
			end
		end
	end

endmodule

FILE: sv/nkrl_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the record list: sequences insert, search, listing and close-up.
// Depends on nkrl_pkg; talks to nkrl_dp only through command and status structs.
module nkrl_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  nkrl_pkg::dp_stat_t stat,
	output nkrl_pkg::dp_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_READ,
		S_CHECK,
		S_MV_READ,
		S_MV_WRITE
	} state_t;

	state_t state_q;
	state_t state_nxt;

	assign busy = (state_q != S_IDLE);

	// Commands and next state from the current state and datapath status.
	always_comb begin
		cmd = '0;
		cmd.emit_status = nkrl_pkg::ST_OK;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_nxt = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				state_nxt = S_IDLE;
				if (stat.cmd == nkrl_pkg::CMD_INSERT) begin
					cmd.emit = 1'b1;
					cmd.emit_last = 1'b1;
					if (stat.full) begin
						cmd.emit_status = nkrl_pkg::ST_FULL;
					end else begin
						cmd.wr_ins = 1'b1;
						cmd.cnt_inc = 1'b1;
					end
				end else if (stat.empty) begin
					cmd.emit = 1'b1;
					cmd.emit_last = 1'b1;
					cmd.emit_status = nkrl_pkg::ST_EMPTY;
				end else begin
					cmd.idx_clr = 1'b1;
					state_nxt = S_READ;
				end
			end
			S_READ: begin
				state_nxt = S_CHECK;
			end
			S_CHECK: begin
				if (stat.cmd == nkrl_pkg::CMD_LIST) begin
					cmd.emit = 1'b1;
					cmd.emit_rec = 1'b1;
					cmd.emit_last = stat.at_last;
					if (stat.at_last) begin
						state_nxt = S_IDLE;
					end else begin
						cmd.idx_inc = 1'b1;
						state_nxt = S_READ;
					end
				end else if (stat.match) begin
					if (stat.cmd == nkrl_pkg::CMD_LOOKUP) begin
						cmd.emit = 1'b1;
						cmd.emit_rec = 1'b1;
						cmd.emit_last = 1'b1;
						state_nxt = S_IDLE;
					end else if (stat.at_last) begin
						// Removing the final record needs no close-up.
						cmd.cnt_dec = 1'b1;
						cmd.emit = 1'b1;
						cmd.emit_last = 1'b1;
						state_nxt = S_IDLE;
					end else begin
						state_nxt = S_MV_READ;
					end
				end else if (stat.at_last) begin
					cmd.emit = 1'b1;
					cmd.emit_last = 1'b1;
					cmd.emit_status = nkrl_pkg::ST_NOT_FOUND;
					state_nxt = S_IDLE;
				end else begin
					cmd.idx_inc = 1'b1;
					state_nxt = S_READ;
				end
			end
			S_MV_READ: begin
				cmd.rd_next = 1'b1;
				state_nxt = S_MV_WRITE;
			end
			S_MV_WRITE: begin
				cmd.wr_move = 1'b1;
				if (stat.move_more) begin
					cmd.idx_inc = 1'b1;
					state_nxt = S_MV_READ;
				end else begin
					cmd.cnt_dec = 1'b1;
					cmd.emit = 1'b1;
					cmd.emit_last = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

FILE: sv/name_keyed_record_list.sv
`timescale 1ns / 1ps
// Insert: the result strobe is registered from the dispatch state, and busy falls with it.
// Remove, lookup and list walk the record RAM entry by entry, a read and then a compare
// state for each; a remove then closes up the list with a read and a copy state per
// moved entry, all through its single read port. A new request is taken once busy falls.
// Results cannot be stalled. Reset empties the list at once; stored records are not
// cleared and never used before they are written.
module name_keyed_record_list #(
	parameter int CAPACITY = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         command,
	input  logic [63:0]        name_chars_0_7,
	input  logic [63:0]        name_chars_8_15,
	input  logic [23:0]        name_chars_16_18,
	input  logic signed [31:0] record_id,
	output logic               done,
	output logic [1:0]         status,
	output logic [63:0]        out_chars_0_7,
	output logic [63:0]        out_chars_8_15,
	output logic [23:0]        out_chars_16_18,
	output logic signed [31:0] out_id,
	output logic               last_of_run
);

	nkrl_pkg::dp_cmd_t  dp_cmd;
	nkrl_pkg::dp_stat_t dp_stat;

	nkrl_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.stat  (dp_stat),
		.cmd   (dp_cmd)
	);

	nkrl_dp #(
		.CAPACITY(CAPACITY)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (dp_cmd),
		.stat            (dp_stat),
		.command         (command),
		.name_chars_0_7  (name_chars_0_7),
		.name_chars_8_15 (name_chars_8_15),
		.name_chars_16_18(name_chars_16_18),
		.record_id       (record_id),
		.done            (done),
		.status          (status),
		.out_chars_0_7   (out_chars_0_7),
		.out_chars_8_15  (out_chars_8_15),
		.out_chars_16_18 (out_chars_16_18),
		.out_id          (out_id),
		.last_of_run     (last_of_run)
	);

	// An accepted request always keeps the block busy in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request accepted but block not busy");

	// Result strobes never come back to back.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe on consecutive cycles");

	// An error status ends its run.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != nkrl_pkg::ST_OK) |-> last_of_run)
		else $error("error result not marked last");

	// An error status carries no record.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != nkrl_pkg::ST_OK) |-> (out_id == '0 && out_chars_0_7 == '0))
		else $error("error result carries record data");

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for name_keyed_record_list: directed and random requests,
// checked against a predictor of the record list. Depends on nkrl_pkg and the block.
module testbench;

	localparam int SLOTS        = 16;
	localparam int POOL_SIZE    = 8;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 4 * SLOTS + 16;

	// One expected result of a request.
	typedef struct {
		nkrl_pkg::status_t  st;
		nkrl_pkg::name_t    name;
		logic signed [31:0] id;
		logic               last;
	} outcome_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         command;
	logic [63:0]        name_chars_0_7;
	logic [63:0]        name_chars_8_15;
	logic [23:0]        name_chars_16_18;
	logic signed [31:0] record_id;
	logic               done;
	logic [1:0]         status;
	logic [63:0]        out_chars_0_7;
	logic [63:0]        out_chars_8_15;
	logic [23:0]        out_chars_16_18;
	logic signed [31:0] out_id;
	logic               last_of_run;

	// Predicted contents of the list.
	nkrl_pkg::name_t    rec_name [SLOTS];
	logic signed [31:0] rec_id [SLOTS];
	int                 held;

	outcome_t           pending_results [$];
	outcome_t           head_result;
	logic [7:0]         pool_text [POOL_SIZE][nkrl_pkg::NAME_BYTES];
	int                 pool_len [POOL_SIZE];
	int                 idle_pct;
	int                 mismatches;
	int                 results_seen;
	int                 cycle_count;
	int                 req_count [4];
	int                 full_hits;
	int                 empty_hits;

	name_keyed_record_list #(.CAPACITY(SLOTS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.name_chars_0_7(name_chars_0_7),
		.name_chars_8_15(name_chars_8_15),
		.name_chars_16_18(name_chars_16_18),
		.record_id(record_id),
		.done(done),
		.status(status),
		.out_chars_0_7(out_chars_0_7),
		.out_chars_8_15(out_chars_8_15),
		.out_chars_16_18(out_chars_16_18),
		.out_id(out_id),
		.last_of_run(last_of_run)
	);

	// Free-running clock, 20 ns period.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding.",
				cycle_count, pending_results.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Upper-case a..z up to the first NUL and clear every byte from it on.
	function automatic nkrl_pkg::name_t fold_name(nkrl_pkg::name_t raw);
		logic [nkrl_pkg::NAME_BYTES*8-1:0] flat;
		logic [7:0]                        ch;
		bit                                ended;
		flat = raw;
		ended = 1'b0;
		for (int i = 0; i < nkrl_pkg::NAME_BYTES; i++) begin
			ch = flat[nkrl_pkg::NAME_BYTES*8-1-8*i -: 8];
			if (ch == 8'h00) begin
				ended = 1'b1;
			end
			if (ended) begin
				ch = 8'h00;
			end else if (ch >= "a" && ch <= "z") begin
				ch = ch - 8'd32;
			end
			flat[nkrl_pkg::NAME_BYTES*8-1-8*i -: 8] = ch;
		end
		return flat;
	endfunction

	// Work out the results of one accepted request and update the predicted list.
	function automatic void predict_request(nkrl_pkg::cmd_t c, nkrl_pkg::name_t raw,
			logic signed [31:0] id);
		nkrl_pkg::name_t key;
		outcome_t        o;
		int              hit;
		key = fold_name(raw);
		o.st = nkrl_pkg::ST_OK;
		o.name = '0;
		o.id = '0;
		o.last = 1'b1;
		req_count[c]++;
		if (c == nkrl_pkg::CMD_INSERT) begin
			if (held == SLOTS) begin
				o.st = nkrl_pkg::ST_FULL;
				full_hits++;
			end else begin
				rec_name[held] = key;
				rec_id[held] = id;
				held++;
			end
			pending_results.push_back(o);
		end else if (held == 0) begin
			o.st = nkrl_pkg::ST_EMPTY;
			empty_hits++;
			pending_results.push_back(o);
		end else if (c == nkrl_pkg::CMD_LIST) begin
			for (int i = 0; i < held; i++) begin
				o.name = rec_name[i];
				o.id = rec_id[i];
				o.last = (i == held - 1);
				pending_results.push_back(o);
			end
		end else begin
			hit = -1;
			for (int i = 0; i < held; i++) begin
				if (hit < 0 && rec_name[i] == key) begin
					hit = i;
				end
			end
			if (hit < 0) begin
				o.st = nkrl_pkg::ST_NOT_FOUND;
			end else if (c == nkrl_pkg::CMD_LOOKUP) begin
				o.name = rec_name[hit];
				o.id = rec_id[hit];
			end else begin
				for (int i = hit; i < held - 1; i++) begin
					rec_name[i] = rec_name[i + 1];
					rec_id[i] = rec_id[i + 1];
				end
				held--;
			end
			pending_results.push_back(o);
		end
	endfunction

	// Report one field that differs from its expectation.
	task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %h, got %h", field, want, got);
			mismatches++;
		end
	endtask

	// Compare every result strobe with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("Result strobe with no request waiting for it.");
				mismatches++;
			end else begin
				head_result = pending_results.pop_front();
				results_seen++;
				check_field("status", 64'(head_result.st), 64'(status));
				check_field("out_chars_0_7", head_result.name.chars_0_7, out_chars_0_7);
				check_field("out_chars_8_15", head_result.name.chars_8_15, out_chars_8_15);
				check_field("out_chars_16_18", 64'(head_result.name.chars_16_18),
					64'(out_chars_16_18));
				check_field("out_id", 64'(head_result.id), 64'(out_id));
				check_field("last_of_run", 64'(head_result.last), 64'(last_of_run));
			end
		end
	end

	// Present one request, idling at random first, and predict it once accepted.
	task automatic send_request(nkrl_pkg::cmd_t c, nkrl_pkg::name_t nm,
			logic signed [31:0] id);
		@(negedge clk);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		command <= c;
		name_chars_0_7 <= nm.chars_0_7;
		name_chars_8_15 <= nm.chars_8_15;
		name_chars_16_18 <= nm.chars_16_18;
		record_id <= id;
		do begin
			@(posedge clk);
		end while (busy);
		predict_request(c, nm, id);
	endtask

	// Drop start and hold off until every predicted result has arrived.
	task automatic wait_all_results();
		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Pack text into a name; optionally fill the bytes past the terminator with junk.
	function automatic nkrl_pkg::name_t pack_text(string s, bit junk_tail);
		logic [nkrl_pkg::NAME_BYTES*8-1:0] flat;
		logic [7:0]                        ch;
		flat = '0;
		for (int i = 0; i < nkrl_pkg::NAME_BYTES; i++) begin
			if (i < s.len()) begin
				ch = s[i];
			end else if (junk_tail && i > s.len()) begin
				ch = 8'($urandom_range(1, 255));
			end else begin
				ch = 8'h00;
			end
			flat[nkrl_pkg::NAME_BYTES*8-1-8*i -: 8] = ch;
		end
		return flat;
	endfunction

	// A pool name with its letters in random case and, at random, junk past its end.
	function automatic nkrl_pkg::name_t pool_name(int k);
		logic [nkrl_pkg::NAME_BYTES*8-1:0] flat;
		logic [7:0]                        ch;
		bit                                junk;
		flat = '0;
		junk = 1'($urandom_range(0, 1));
		for (int i = 0; i < nkrl_pkg::NAME_BYTES; i++) begin
			if (i < pool_len[k]) begin
				ch = pool_text[k][i];
				if (((ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z")) &&
						$urandom_range(0, 1)) begin
					ch = ch ^ 8'h20;
				end
			end else if (junk && i > pool_len[k]) begin
				ch = 8'($urandom_range(0, 255));
			end else begin
				ch = 8'h00;
			end
			flat[nkrl_pkg::NAME_BYTES*8-1-8*i -: 8] = ch;
		end
		return flat;
	endfunction

	// Remove, lookup and list on a store that holds nothing.
	task automatic test_empty_store();
		send_request(nkrl_pkg::CMD_REMOVE, pack_text("ALICE", 1'b0), 32'sd5);
		send_request(nkrl_pkg::CMD_LOOKUP, pack_text("alice", 1'b1), 32'sd0);
		send_request(nkrl_pkg::CMD_LIST, '0, -32'sd1);
	endtask

	// Fill the store with edge-case names and ids, then insert once more.
	task automatic test_fill_store();
		send_request(nkrl_pkg::CMD_INSERT, '1, 32'sh80000000);
		send_request(nkrl_pkg::CMD_INSERT, pack_text("", 1'b1), 32'sh7fffffff);
		send_request(nkrl_pkg::CMD_INSERT, pack_text("alice", 1'b1), 32'sd0);
		send_request(nkrl_pkg::CMD_INSERT, pack_text("ALICE", 1'b0), -32'sd1);
		send_request(nkrl_pkg::CMD_INSERT, pack_text("line\nbreak", 1'b0), 32'sd1);
		send_request(nkrl_pkg::CMD_INSERT, pack_text("`az{@AZ[", 1'b1), 32'sd42);
		send_request(nkrl_pkg::CMD_INSERT, pack_text("NINETEEN_chars_long", 1'b0),
			32'sd1000);
		for (int k = 7; k < SLOTS; k++) begin
			send_request(nkrl_pkg::CMD_INSERT,
				pack_text($sformatf("rec%0d", k), 1'(k % 2)), $urandom);
		end
		send_request(nkrl_pkg::CMD_INSERT, pack_text("overflow", 1'b0), 32'sd7);
	endtask

	// Listing, case-blind lookups, a miss and removal of the first duplicate.
	task automatic test_search_and_remove();
		send_request(nkrl_pkg::CMD_LIST, '0, 32'sd0);
		send_request(nkrl_pkg::CMD_LOOKUP, pack_text("ALIce", 1'b1), 32'sd0);
		send_request(nkrl_pkg::CMD_LOOKUP, pack_text("nobody", 1'b0), 32'sd0);
		send_request(nkrl_pkg::CMD_REMOVE, pack_text("Alice", 1'b0), 32'sd0);
		send_request(nkrl_pkg::CMD_LOOKUP, pack_text("", 1'b0), 32'sd0);
	endtask

	// Build a small pool of names so that random requests often match.
	task automatic make_pool();
		int roll;
		for (int k = 0; k < POOL_SIZE; k++) begin
			pool_len[k] = (k == 0) ? 0 : (k == 1) ? nkrl_pkg::NAME_BYTES :
				$urandom_range(1, 12);
			for (int i = 0; i < nkrl_pkg::NAME_BYTES; i++) begin
				roll = $urandom_range(0, 19);
				if (roll < 15) begin
					pool_text[k][i] = 8'("A" + $urandom_range(0, 25));
				end else if (roll < 17) begin
					pool_text[k][i] = 8'("0" + $urandom_range(0, 9));
				end else if (roll < 18) begin
					pool_text[k][i] = 8'h0a;
				end else begin
					pool_text[k][i] = 8'($urandom_range(1, 255));
				end
			end
		end
	endtask

	// Random traffic: mostly pool names, some raw noise, insert rate tracks occupancy.
	task automatic test_random_traffic(int items, int idle);
		nkrl_pkg::cmd_t     c;
		nkrl_pkg::name_t    nm;
		logic [159:0]       noise;
		logic signed [31:0] id;
		int                 ins_pct;
		int                 pick;
		idle_pct = idle;
		repeat (items) begin
			ins_pct = (held < 4) ? 60 : (held > 13) ? 20 : 40;
			if ($urandom_range(0, 99) < ins_pct) begin
				c = nkrl_pkg::CMD_INSERT;
			end else begin
				pick = $urandom_range(0, 9);
				c = (pick < 4) ? nkrl_pkg::CMD_REMOVE :
					(pick < 8) ? nkrl_pkg::CMD_LOOKUP : nkrl_pkg::CMD_LIST;
			end
			if ($urandom_range(0, 99) < 15) begin
				noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
				nm = noise[nkrl_pkg::NAME_BYTES*8-1:0];
			end else begin
				nm = pool_name($urandom_range(0, POOL_SIZE - 1));
			end
			case ($urandom_range(0, 7))
				0: id = 32'sh80000000;
				1: id = 32'sh7fffffff;
				default: id = $urandom;
			endcase
			send_request(c, nm, id);
		end
	endtask

	// Reset, directed tests, random phases with different idling, then the verdict.
	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		command = nkrl_pkg::CMD_INSERT;
		name_chars_0_7 = '0;
		name_chars_8_15 = '0;
		name_chars_16_18 = '0;
		record_id = '0;
		held = 0;
		idle_pct = 0;
		mismatches = 0;
		results_seen = 0;
		full_hits = 0;
		empty_hits = 0;
		for (int i = 0; i < 4; i++) begin
			req_count[i] = 0;
		end
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_store();
		test_fill_store();
		test_search_and_remove();
		wait_all_results();

		make_pool();
		test_random_traffic(90, 0);
		wait_all_results();
		test_random_traffic(90, 75);
		wait_all_results();
		test_random_traffic(90, 0);
		wait_all_results();
		test_random_traffic(90, 21);
		wait_all_results();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d requests (%0d insert, %0d remove, %0d lookup, %0d list),",
			req_count[0] + req_count[1] + req_count[2] + req_count[3], req_count[0],
			req_count[1], req_count[2], req_count[3]);
		$display("%0d results checked; store full %0d times, empty %0d times; %s",
			results_seen, full_hits, empty_hits, "sender idle at 0, 75 and 21 percent.");
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
